// File: hdl/bmtc_pkg.sv
`default_nettype none
package bmtc_pkg;

	localparam int SAMPLE_W = 22;
	localparam int IMG_W    = 21;
	localparam int TILE_W   = 17;
	localparam int COORD_W  = 20;
	localparam int LOCAL_W  = 16;
	localparam int SLOT_OUT_W = 3;
	localparam int MODE_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 21;

	// Bounds applied to the size registers before use.
	localparam logic [IMG_W-1:0]  MAX_IMG  = IMG_W'(1048576);
	localparam logic [TILE_W-1:0] MAX_TILE = TILE_W'(65536);

	// The divider works on 22-bit dividends and 21-bit divisors.
	localparam int DIV_STEPS = 22;
	localparam int DIV_CNT_W = 5;

	localparam logic [MODE_W-1:0] MODE_ZERO    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLAMP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REFLECT = 2'd2;
	// Unassigned encoding; it behaves as zero fill.
	localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_TILE_W       = 3'd2,
		REG_TILE_H       = 3'd3,
		REG_BORDER_MODE  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOOK,
		ST_OUT
	} state_t;

	// Jobs of the shared divider, in the order they run.
	typedef enum logic [1:0] {
		PH_REFL_X,
		PH_REFL_Y,
		PH_DIV_X,
		PH_DIV_Y
	} phase_t;

endpackage
`default_nettype wire

// File: hdl/bmtc_if.sv
`default_nettype none
interface bmtc_in_if;
	logic valid;
	logic ready;
	logic signed [bmtc_pkg::SAMPLE_W-1:0] sample_x;
	logic signed [bmtc_pkg::SAMPLE_W-1:0] sample_y;
	modport source (output valid, sample_x, sample_y, input ready);
	modport sink (input valid, sample_x, sample_y, output ready);
endinterface

interface bmtc_out_if;
	logic valid;
	logic ready;
	logic zero_fill;
	logic [bmtc_pkg::COORD_W-1:0] remap_x;
	logic [bmtc_pkg::COORD_W-1:0] remap_y;
	logic [bmtc_pkg::COORD_W-1:0] tile_idx_x;
	logic [bmtc_pkg::COORD_W-1:0] tile_idx_y;
	logic [bmtc_pkg::LOCAL_W-1:0] local_x;
	logic [bmtc_pkg::LOCAL_W-1:0] local_y;
	logic tile_hit;
	logic [bmtc_pkg::SLOT_OUT_W-1:0] slot_index;
	modport source (output valid, zero_fill, remap_x, remap_y, tile_idx_x, tile_idx_y,
		local_x, local_y, tile_hit, slot_index, input ready);
	modport sink (input valid, zero_fill, remap_x, remap_y, tile_idx_x, tile_idx_y,
		local_x, local_y, tile_hit, slot_index, output ready);
endinterface

interface bmtc_cfg_if;
	logic valid;
	logic ready;
	logic [bmtc_pkg::CFG_IDX_W-1:0] index;
	logic [bmtc_pkg::CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/border_mapped_tile_cache_lookup_unit.sv
// A zero-fill request presents its result in the cycle after acceptance. Other requests run the shared
// 22-step divider twice (in-image or clamp) or four times (mirror reflect), then scan the tag
// store slot by slot until a hit, or a miss on the last slot.
// One request at a time; the next is taken the cycle after the result is taken.
// Reset (arst_n low, asynchronous) restores the register defaults, clears all slot valid bits
// and the eviction pointer, and empties the output register. No clearing pass is needed.
`default_nettype none
module border_mapped_tile_cache_lookup_unit #(
	parameter int CACHE_SLOTS = 8
) (
	input wire logic    clk,
	input wire logic    arst_n,
	bmtc_in_if.sink     sample,
	bmtc_out_if.source  result,
	bmtc_cfg_if.sink    cfg
);

	localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_SLOTS - 1);

	localparam int SW = bmtc_pkg::SAMPLE_W;
	localparam int IW = bmtc_pkg::IMG_W;
	localparam int TW = bmtc_pkg::TILE_W;
	localparam int CW = bmtc_pkg::COORD_W;
	localparam int LW = bmtc_pkg::LOCAL_W;

	// ------------------------------------------------------------------
	// Configuration registers. The port never stalls; writes to indexes
	// beyond the register list are dropped.
	// ------------------------------------------------------------------
	logic [IW-1:0] image_width_q;
	logic [IW-1:0] image_height_q;
	logic [TW-1:0] tile_w_q;
	logic [TW-1:0] tile_h_q;
	logic [bmtc_pkg::MODE_W-1:0] border_mode_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IW'(1024);
			image_height_q <= IW'(1024);
			tile_w_q       <= TW'(256);
			tile_h_q       <= TW'(256);
			border_mode_q  <= bmtc_pkg::MODE_ZERO;
		end else if (cfg.valid) begin
			unique case (bmtc_pkg::cfg_reg_t'(cfg.index))
				bmtc_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg.data;
				bmtc_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg.data;
				bmtc_pkg::REG_TILE_W:       tile_w_q       <= cfg.data[TW-1:0];
				bmtc_pkg::REG_TILE_H:       tile_h_q       <= cfg.data[TW-1:0];
				bmtc_pkg::REG_BORDER_MODE:  border_mode_q  <= cfg.data[bmtc_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sizes as actually used: zero acts as one, oversized values saturate.
	logic [IW-1:0] w_b, h_b;
	logic [TW-1:0] tw_b, th_b;

	always_comb begin
		w_b  = (image_width_q == '0) ? IW'(1)
			: ((image_width_q > bmtc_pkg::MAX_IMG) ? bmtc_pkg::MAX_IMG : image_width_q);
		h_b  = (image_height_q == '0) ? IW'(1)
			: ((image_height_q > bmtc_pkg::MAX_IMG) ? bmtc_pkg::MAX_IMG : image_height_q);
		tw_b = (tile_w_q == '0) ? TW'(1)
			: ((tile_w_q > bmtc_pkg::MAX_TILE) ? bmtc_pkg::MAX_TILE : tile_w_q);
		th_b = (tile_h_q == '0) ? TW'(1)
			: ((tile_h_q > bmtc_pkg::MAX_TILE) ? bmtc_pkg::MAX_TILE : tile_h_q);
	end

	// Mirror period 2(N-1) per axis. It is zero for a one-pixel axis,
	// which the fold step overrides to coordinate 0.
	logic [IW-1:0] w_m1, h_m1, period_x, period_y;
	assign w_m1     = w_b - IW'(1);
	assign h_m1     = h_b - IW'(1);
	assign period_x = {w_m1[IW-2:0], 1'b0};
	assign period_y = {h_m1[IW-2:0], 1'b0};

	// ------------------------------------------------------------------
	// Classification of the incoming request.
	// ------------------------------------------------------------------
	logic [SW-1:0] sx, sy;
	logic          out_x, out_y, outside, zf_now, refl_now;
	logic [CW-1:0] direct_x, direct_y;

	assign sx = sample.sample_x;
	assign sy = sample.sample_y;

	always_comb begin
		out_x    = sx[SW-1] || ({1'b0, sx[SW-2:0]} >= {1'b0, w_b});
		out_y    = sy[SW-1] || ({1'b0, sy[SW-2:0]} >= {1'b0, h_b});
		outside  = out_x || out_y;
		zf_now   = outside && (border_mode_q != bmtc_pkg::MODE_CLAMP)
			&& (border_mode_q != bmtc_pkg::MODE_REFLECT);
		refl_now = outside && (border_mode_q == bmtc_pkg::MODE_REFLECT);
		// In-image samples pass unchanged; otherwise this is the clamp result.
		if (sx[SW-1])
			direct_x = '0;
		else if (out_x)
			direct_x = w_m1[CW-1:0];
		else
			direct_x = sx[CW-1:0];
		if (sy[SW-1])
			direct_y = '0;
		else if (out_y)
			direct_y = h_m1[CW-1:0];
		else
			direct_y = sy[CW-1:0];
	end

	// ------------------------------------------------------------------
	// Shared restoring divider: one quotient bit per cycle. The dividend
	// register shifts out its bits and collects the quotient in their place.
	// ------------------------------------------------------------------
	bmtc_pkg::state_t state_q, state_d;
	bmtc_pkg::phase_t phase_q;

	logic [SW-1:0] div_num_q, div_rem_q;
	logic [IW-1:0] div_den_q;
	logic [bmtc_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [SW-1:0] rem_sh, rem_nx, num_nx;
	logic          div_ge, div_last;

	always_comb begin
		rem_sh   = {div_rem_q[SW-2:0], div_num_q[SW-1]};
		div_ge   = rem_sh >= {1'b0, div_den_q};
		rem_nx   = div_ge ? (rem_sh - {1'b0, div_den_q}) : rem_sh;
		num_nx   = {div_num_q[SW-2:0], div_ge};
		div_last = div_cnt_q == bmtc_pkg::DIV_CNT_W'(bmtc_pkg::DIV_STEPS - 1);
	end

	// Fold of a reflected remainder back into the image.
	logic [CW-1:0] fold_val;
	logic [IW-1:0] fold_n;
	always_comb begin
		fold_n = (phase_q == bmtc_pkg::PH_REFL_X) ? w_b : h_b;
		if (fold_n == IW'(1))
			fold_val = '0;
		else if (rem_nx[IW-1:0] >= fold_n)
			fold_val = CW'(div_den_q - rem_nx[IW-1:0]);
		else
			fold_val = rem_nx[CW-1:0];
	end

	logic [SW-1:0] sy_q;
	logic [CW-1:0] mx_q, my_q, col_q, row_q;
	logic [LW-1:0] lx_q, ly_q;

	// ------------------------------------------------------------------
	// Tag store and slot scan. Tags sit in a memory read one slot per
	// cycle; the read data is registered and comes back in the following cycle with its slot number.
	// ------------------------------------------------------------------
	logic [CW-1:0] tag_col_mem [CACHE_SLOTS];
	logic [CW-1:0] tag_row_mem [CACHE_SLOTS];
	logic [CACHE_SLOTS-1:0] slot_valid_q;
	logic [SLOT_W-1:0] evict_ptr_q, rd_addr_q, idx_s1;
	logic [CW-1:0] rd_col_s1, rd_row_s1;
	logic          chk_s1, hit_now, miss_now;

	always_comb begin
		hit_now  = (state_q == bmtc_pkg::ST_LOOK) && chk_s1 && slot_valid_q[idx_s1]
			&& (rd_col_s1 == col_q) && (rd_row_s1 == row_q);
		miss_now = (state_q == bmtc_pkg::ST_LOOK) && chk_s1 && !hit_now
			&& (idx_s1 == LAST_SLOT);
	end

	always_ff @(posedge clk) begin
		rd_col_s1 <= tag_col_mem[rd_addr_q];
		rd_row_s1 <= tag_row_mem[rd_addr_q];
		if (miss_now) begin
			tag_col_mem[evict_ptr_q] <= col_q;
			tag_row_mem[evict_ptr_q] <= row_q;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	logic sample_acc, result_acc;

	assign sample.ready = state_q == bmtc_pkg::ST_IDLE;
	assign sample_acc   = sample.valid && sample.ready;
	assign result_acc   = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bmtc_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bmtc_pkg::ST_IDLE: begin
				if (sample_acc)
					state_d = zf_now ? bmtc_pkg::ST_OUT : bmtc_pkg::ST_DIV;
			end
			bmtc_pkg::ST_DIV: begin
				if (div_last && (phase_q == bmtc_pkg::PH_DIV_Y))
					state_d = bmtc_pkg::ST_LOOK;
			end
			bmtc_pkg::ST_LOOK: begin
				if (hit_now || miss_now)
					state_d = bmtc_pkg::ST_OUT;
			end
			bmtc_pkg::ST_OUT: begin
				if (result_acc)
					state_d = bmtc_pkg::ST_IDLE;
			end
			default: state_d = bmtc_pkg::ST_IDLE;
		endcase
	end

	// Control registers of the sequencer and the cache.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= bmtc_pkg::PH_REFL_X;
			div_cnt_q    <= '0;
			slot_valid_q <= '0;
			evict_ptr_q  <= '0;
			rd_addr_q    <= '0;
			chk_s1       <= 1'b0;
			result.valid <= 1'b0;
		end else begin
			if (sample_acc) begin
				phase_q   <= refl_now ? bmtc_pkg::PH_REFL_X : bmtc_pkg::PH_DIV_X;
				div_cnt_q <= '0;
			end else if (state_q == bmtc_pkg::ST_DIV) begin
				div_cnt_q <= div_last ? '0 : div_cnt_q + bmtc_pkg::DIV_CNT_W'(1);
				if (div_last)
					phase_q <= bmtc_pkg::phase_t'(phase_q + 2'd1);
			end
			if (state_q == bmtc_pkg::ST_LOOK) begin
				chk_s1 <= 1'b1;
				if (rd_addr_q != LAST_SLOT)
					rd_addr_q <= rd_addr_q + SLOT_W'(1);
			end else begin
				chk_s1    <= 1'b0;
				rd_addr_q <= '0;
			end
			if (miss_now) begin
				slot_valid_q[evict_ptr_q] <= 1'b1;
				evict_ptr_q <= (evict_ptr_q == LAST_SLOT) ? '0 : evict_ptr_q + SLOT_W'(1);
			end
			if ((state_q != bmtc_pkg::ST_OUT) && (state_d == bmtc_pkg::ST_OUT))
				result.valid <= 1'b1;
			else if (result_acc)
				result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr_q;
		if (sample_acc) begin
			sy_q      <= sy;
			mx_q      <= direct_x;
			my_q      <= direct_y;
			div_rem_q <= '0;
			if (refl_now) begin
				div_num_q <= sx[SW-1] ? (~sx + SW'(1)) : sx;
				div_den_q <= period_x;
			end else begin
				div_num_q <= SW'(direct_x);
				div_den_q <= IW'(tw_b);
			end
		end else if (state_q == bmtc_pkg::ST_DIV) begin
			if (!div_last) begin
				div_num_q <= num_nx;
				div_rem_q <= rem_nx;
			end else begin
				// Store this job's result and, unless it is the last, load the next one.
				div_rem_q <= '0;
				unique case (phase_q)
					bmtc_pkg::PH_REFL_X: begin
						mx_q      <= fold_val;
						div_num_q <= sy_q[SW-1] ? (~sy_q + SW'(1)) : sy_q;
						div_den_q <= period_y;
					end
					bmtc_pkg::PH_REFL_Y: begin
						my_q      <= fold_val;
						div_num_q <= SW'(mx_q);
						div_den_q <= IW'(tw_b);
					end
					bmtc_pkg::PH_DIV_X: begin
						col_q     <= num_nx[CW-1:0];
						lx_q      <= rem_nx[LW-1:0];
						div_num_q <= SW'(my_q);
						div_den_q <= IW'(th_b);
					end
					bmtc_pkg::PH_DIV_Y: begin
						row_q     <= num_nx[CW-1:0];
						ly_q      <= rem_nx[LW-1:0];
						div_num_q <= num_nx;
						div_den_q <= div_den_q;
					end
					default: ;
				endcase
			end
		end
	end

	// Result register, loaded when the request finishes.
	always_ff @(posedge clk) begin
		if ((state_q == bmtc_pkg::ST_IDLE) && sample_acc && zf_now) begin
			result.zero_fill  <= 1'b1;
			result.remap_x    <= '0;
			result.remap_y    <= '0;
			result.tile_idx_x <= '0;
			result.tile_idx_y <= '0;
			result.local_x    <= '0;
			result.local_y    <= '0;
			result.tile_hit   <= 1'b0;
			result.slot_index <= '0;
		end else if (hit_now || miss_now) begin
			result.zero_fill  <= 1'b0;
			result.remap_x    <= mx_q;
			result.remap_y    <= my_q;
			result.tile_idx_x <= col_q;
			result.tile_idx_y <= row_q;
			result.local_x    <= lx_q;
			result.local_y    <= ly_q;
			result.tile_hit   <= hit_now;
			result.slot_index <= bmtc_pkg::SLOT_OUT_W'(hit_now ? idx_s1 : evict_ptr_q);
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> !result.valid)
		else $error("request taken while a result is pending");

	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.zero_fill) |-> (!result.tile_hit && result.remap_x == '0))
		else $error("zero-fill result carries lookup data");

	a_miss_marks: assert property (@(posedge clk) disable iff (!arst_n)
		miss_now |=> slot_valid_q[$past(evict_ptr_q)])
		else $error("claimed slot not marked valid");

	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		hit_now |-> slot_valid_q[idx_s1])
		else $error("hit on an invalid slot");

	a_local_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.zero_fill) |-> ({1'b0, result.local_x} < tw_b))
		else $error("column offset not below tile width");

endmodule
`default_nettype wire
